// File: rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg: shared types, constants and tables of the seven-segment driver
// Holds the operation codes, the queue entry layout, the segment table and
// the reciprocal constants used to split a value into decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

  // Largest number of digits the hardware can show and scan.
  localparam int DIGIT_COUNT_MAX = 3;
  // Digits the front end always produces.
  localparam int DIGIT_SLOTS     = 3;
  localparam int SCAN_PHASES     = 6;
  localparam int QUEUE_DEPTH     = 2;

  localparam int VALUE_W   = 20;
  localparam int SCALED_W  = 22;
  localparam int PRODUCT_W = 30;
  localparam int SEG_W     = 8;
  localparam int COM_W     = 3;
  localparam int PHASE_W   = 3;
  localparam int DCOUNT_W  = 2;
  localparam int POS_W     = 2;

  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;
  localparam int ROUND_HALF = 128;
  localparam int FRAC_BITS  = 8;

  // Reciprocal multipliers, exact for any 32-bit dividend.
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int          SHIFT_10   = 35;
  localparam logic [31:0] RECIP_100  = 32'h51EB_851F;
  localparam int          SHIFT_100  = 37;
  localparam logic [31:0] RECIP_1000 = 32'h1062_4DD3;
  localparam int          SHIFT_1000 = 38;

  // Register indexes of the configuration port.
  localparam logic CFG_DIGIT_COUNT   = 1'b0;
  localparam logic CFG_ACTIVE_HIGH   = 1'b1;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SET_INT   = 2'd1,
    FUNC_SET_FIXED = 2'd2,
    FUNC_CLEAR     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    op_e                                op;
    logic [DIGIT_SLOTS-1:0][SEG_W-1:0]  patterns;
    logic                               point_en;
    logic [POS_W-1:0]                   point_pos;
  } entry_t;

  typedef struct packed {
    logic [DCOUNT_W-1:0] digit_count;
    logic                segment_active_high;
  } cfg_t;

  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h27;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [9:0] pow10(input logic [POS_W-1:0] pos);
    logic [9:0] p;
    unique case (pos)
      2'd0:    p = 10'd1;
      2'd1:    p = 10'd10;
      2'd2:    p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

  // Common lines for a scan phase; a low level selects a digit.
  function automatic logic [COM_W-1:0] common_for_phase(input logic [PHASE_W-1:0] phase);
    logic [COM_W-1:0] com;
    unique case (phase)
      3'd0:    com = 3'b110;
      3'd1:    com = 3'b101;
      3'd2:    com = 3'b011;
      default: com = 3'b111;
    endcase
    return com;
  endfunction

endpackage

`default_nettype wire

// File: rtl/multiplexed_seven_segment_driver_core.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver_core: three-digit display scan driver
// Accepts tick, set and clear requests, keeps the digit patterns and returns
// segment and common line levels for each scan step.
//
// Channel  Dir  Handshake              Contents
// s_axis   in   tvalid/tready          tuser: func; tdata: value, point_pos
// m_axis   out  tvalid/tready          tdata: segment_levels, common_levels
// cfg      in   cfg_we_i (no stall)    index 0 digit_count, 1 segment_active_high
//
// One request per cycle is sustained while the output does not stall; a tick
// or clear result passes the two front stages, the queue and the output register.
// The front pipeline is set by the reciprocal multiplies of digit splitting.
// Reset clears the pipeline, queue, scan phase and stored patterns at once.
// A stalled output holds its result; the queue lets set requests go on
// draining while a result waits, and the input stalls once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_driver_core #(
  parameter int DigitCountMax = msd_pkg::DIGIT_COUNT_MAX
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // value [19:0], point_pos [21:20]
  input  wire  [1:0]  s_axis_tuser,   // func [1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // segment_levels [7:0], common_levels [10:8]
  input  wire         cfg_we_i,
  input  wire         cfg_index_i,
  input  wire  [1:0]  cfg_wdata_i
);

  msd_pkg::cfg_t   cfg_q;
  logic            push_valid;
  logic            push_ready;
  msd_pkg::entry_t push_entry;
  logic            entry_valid;
  msd_pkg::entry_t entry;
  logic            pop;
  logic [msd_pkg::SEG_W-1:0] segment_levels;
  logic [msd_pkg::COM_W-1:0] common_levels;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_count         <= 2'd3;
      cfg_q.segment_active_high <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        msd_pkg::CFG_DIGIT_COUNT: cfg_q.digit_count         <= cfg_wdata_i;
        msd_pkg::CFG_ACTIVE_HIGH: cfg_q.segment_active_high <= cfg_wdata_i[0];
        default:                  cfg_q                     <= cfg_q;
      endcase
    end
  end

  msd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .func_i       (s_axis_tuser),
    .value_i      (s_axis_tdata[19:0]),
    .point_pos_i  (s_axis_tdata[21:20]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  msd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (entry_valid),
    .pop_i        (pop),
    .pop_entry_o  (entry)
  );

  msd_back #(
    .DigitCountMax (DigitCountMax)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .entry_valid_i    (entry_valid),
    .entry_i          (entry),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .segment_levels_o (segment_levels),
    .common_levels_o  (common_levels)
  );

  assign m_axis_tdata = {5'b0, common_levels, segment_levels};

endmodule

`default_nettype wire

// File: rtl/msd_front.sv
// ----------------------------------------------------------------------------
// msd_front: request intake and digit extraction
// Two pipeline stages: the first scales fixed-point values and rounds, the
// second divides by 10, 100 and 1000 through reciprocal multiplies. The
// digit patterns are encoded on the way into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            req_valid_i,
  output logic                           req_ready_o,
  input  wire  [1:0]                     func_i,
  input  wire  [msd_pkg::VALUE_W-1:0]    value_i,
  input  wire  [msd_pkg::POS_W-1:0]      point_pos_i,
  output logic                           push_valid_o,
  input  wire                            push_ready_i,
  output msd_pkg::entry_t                push_entry_o
);

  localparam int XW = msd_pkg::SCALED_W;
  localparam int PW = XW + 32;

  logic                          s1_valid_q;
  msd_pkg::op_e                  s1_op_q;
  logic [XW-1:0]                 s1_x_q;
  logic                          s1_point_en_q;
  logic [msd_pkg::POS_W-1:0]     s1_pos_q;

  logic                          s2_valid_q;
  msd_pkg::op_e                  s2_op_q;
  logic [XW-1:0]                 s2_x_q;
  logic [18:0]                   s2_q1_q;
  logic [15:0]                   s2_q2_q;
  logic [11:0]                   s2_q3_q;
  logic                          s2_point_en_q;
  logic [msd_pkg::POS_W-1:0]     s2_pos_q;

  logic                          s1_free;
  logic                          s2_free;
  msd_pkg::func_e                func;
  msd_pkg::op_e                  s1_op_d;
  logic [XW-1:0]                 s1_x_d;
  logic [msd_pkg::PRODUCT_W-1:0] scaled;
  logic [PW-1:0]                 prod10;
  logic [PW-1:0]                 prod100;
  logic [PW-1:0]                 prod1000;
  logic [3:0]                    digit [msd_pkg::DIGIT_SLOTS];
  logic [XW-1:0]                 rem0;
  logic [18:0]                   rem1;
  logic [15:0]                   rem2;

  assign s2_free     = !s2_valid_q || push_ready_i;
  assign s1_free     = !s1_valid_q || s2_free;
  assign req_ready_o = s1_free;

  assign func   = msd_pkg::func_e'(func_i);
  assign scaled = msd_pkg::PRODUCT_W'(value_i) * msd_pkg::PRODUCT_W'(msd_pkg::pow10(point_pos_i))
                  + msd_pkg::PRODUCT_W'(msd_pkg::ROUND_HALF);

  always_comb begin
    unique case (func)
      msd_pkg::FUNC_TICK: begin
        s1_op_d = msd_pkg::OP_TICK;
        s1_x_d  = XW'(value_i);
      end
      msd_pkg::FUNC_SET_INT: begin
        s1_op_d = msd_pkg::OP_SET;
        s1_x_d  = XW'(value_i);
      end
      msd_pkg::FUNC_SET_FIXED: begin
        s1_op_d = msd_pkg::OP_SET;
        s1_x_d  = scaled[msd_pkg::FRAC_BITS +: XW];
      end
      default: begin
        s1_op_d = msd_pkg::OP_CLEAR;
        s1_x_d  = XW'(value_i);
      end
    endcase
  end

  assign prod10   = PW'(s1_x_q) * PW'(msd_pkg::RECIP_10);
  assign prod100  = PW'(s1_x_q) * PW'(msd_pkg::RECIP_100);
  assign prod1000 = PW'(s1_x_q) * PW'(msd_pkg::RECIP_1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= req_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_op_q       <= s1_op_d;
      s1_x_q        <= s1_x_d;
      s1_point_en_q <= (func == msd_pkg::FUNC_SET_FIXED) && (point_pos_i != 2'd3);
      s1_pos_q      <= point_pos_i;
    end
    if (s2_free) begin
      s2_op_q       <= s1_op_q;
      s2_x_q        <= s1_x_q;
      s2_q1_q       <= prod10[msd_pkg::SHIFT_10 +: 19];
      s2_q2_q       <= prod100[msd_pkg::SHIFT_100 +: 16];
      s2_q3_q       <= prod1000[msd_pkg::SHIFT_1000 +: 12];
      s2_point_en_q <= s1_point_en_q;
      s2_pos_q      <= s1_pos_q;
    end
  end

  // Each digit is a quotient minus ten times the next quotient.
  assign rem0 = s2_x_q - XW'(s2_q1_q) * XW'(10);
  assign rem1 = s2_q1_q - 19'(s2_q2_q) * 19'(10);
  assign rem2 = s2_q2_q - 16'(s2_q3_q) * 16'(10);
  assign digit[0] = rem0[3:0];
  assign digit[1] = rem1[3:0];
  assign digit[2] = rem2[3:0];

  always_comb begin
    push_entry_o.op        = s2_op_q;
    push_entry_o.point_en  = s2_point_en_q;
    push_entry_o.point_pos = s2_pos_q;
    for (int i = 0; i < msd_pkg::DIGIT_SLOTS; i++) begin
      push_entry_o.patterns[i] = msd_pkg::seg_encode(digit[i]);
    end
  end

  assign push_valid_o = s2_valid_q;

endmodule

`default_nettype wire

// File: rtl/msd_queue.sv
// ----------------------------------------------------------------------------
// msd_queue: short request queue between front and back
// A small register FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  input  msd_pkg::entry_t  push_entry_i,
  output logic             pop_valid_o,
  input  wire              pop_i,
  output msd_pkg::entry_t  pop_entry_o
);

  localparam int DEPTH = msd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  msd_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue holds more entries than its depth");

endmodule

`default_nettype wire

// File: rtl/msd_back.sv
// ----------------------------------------------------------------------------
// msd_back: pattern store, scan sequencer and output register
// Executes queued requests: set updates the stored patterns, tick and clear
// drive one scan phase into the output register; clear blanks active digits.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_back #(
  parameter int DigitCountMax = msd_pkg::DIGIT_COUNT_MAX
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  msd_pkg::cfg_t                cfg_i,
  input  wire                          entry_valid_i,
  input  msd_pkg::entry_t              entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [msd_pkg::SEG_W-1:0]    segment_levels_o,
  output logic [msd_pkg::COM_W-1:0]    common_levels_o
);

  localparam int PW = msd_pkg::PHASE_W;
  localparam int SW = msd_pkg::SEG_W;

  logic [SW-1:0]            pat_q [DigitCountMax];
  logic [PW-1:0]            phase_q;
  logic                     out_valid_q;
  logic [SW-1:0]            seg_q;
  logic [msd_pkg::COM_W-1:0] com_q;

  logic                     out_free;
  logic                     is_set;
  logic                     is_clear;
  logic [SW-1:0]            seg_raw;
  logic [SW-1:0]            seg_d;
  logic [PW-1:0]            phase_d;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_set   = entry_i.op == msd_pkg::OP_SET;
  assign is_clear = entry_i.op == msd_pkg::OP_CLEAR;
  assign pop_o    = entry_valid_i && (is_set || out_free);

  // A clear blanks the active digits while it scans, so its phase shows blank.
  always_comb begin
    seg_raw = '0;
    for (int i = 0; i < DigitCountMax; i++) begin
      if (phase_q == PW'(i) && msd_pkg::DCOUNT_W'(i) < cfg_i.digit_count && !is_clear) begin
        seg_raw = pat_q[i];
      end
    end
    seg_d   = cfg_i.segment_active_high ? seg_raw : ~seg_raw;
    phase_d = (phase_q == PW'(msd_pkg::SCAN_PHASES - 1)) ? '0 : phase_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DigitCountMax; i++) begin
        pat_q[i] <= '0;
      end
    end else begin
      if (pop_o && !is_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (is_set) begin
          for (int i = 0; i < DigitCountMax; i++) begin
            if (msd_pkg::DCOUNT_W'(i) < cfg_i.digit_count) begin
              pat_q[i] <= entry_i.patterns[i]
                          | ((entry_i.point_en && entry_i.point_pos == msd_pkg::POS_W'(i))
                             ? msd_pkg::POINT_BIT : '0);
            end else if (entry_i.point_en && entry_i.point_pos == msd_pkg::POS_W'(i)) begin
              pat_q[i] <= pat_q[i] | msd_pkg::POINT_BIT;
            end
          end
        end else begin
          if (is_clear) begin
            for (int i = 0; i < DigitCountMax; i++) begin
              if (msd_pkg::DCOUNT_W'(i) < cfg_i.digit_count) begin
                pat_q[i] <= '0;
              end
            end
          end
          phase_q <= phase_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !is_set) begin
      seg_q <= seg_d;
      com_q <= msd_pkg::common_for_phase(phase_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segment_levels_o = seg_q;
  assign common_levels_o  = com_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < PW'(msd_pkg::SCAN_PHASES))
    else $error("scan phase out of range");

  a_set_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_set && !out_valid_q) |=> !out_valid_q)
    else $error("set request produced a result");

  a_scan_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !is_set) |=> (out_valid_q && phase_q != $past(phase_q)))
    else $error("scan request did not advance the phase");

endmodule

`default_nettype wire

// File: verif/multiplexed_seven_segment_driver_core_tb.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver_core_tb: self-checking bench for the scan driver
// Sends tick, set integer, set fixed point and clear requests with random
// gaps. A scoreboard predicts the segment and common line levels of every
// tick and clear. The output side stalls at random. The run steps through
// several digit counts and segment polarities, with the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_driver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_PER_PHASE = 147;
  localparam int          DRAIN_CYCLES     = 12;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam logic [19:0] VALUE_ALL_ONES   = 20'hFFFFF;

  localparam logic [7:0] DIGIT_GLYPHS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F
  };

  typedef struct packed {
    msd_pkg::func_e func;
    logic [19:0]    value;
    logic [1:0]     point_pos;
  } request_t;

  // Digit count and polarity for each phase after the first one.
  typedef struct packed {
    logic [1:0] digit_count;
    logic       active_high;
  } setting_t;

  localparam setting_t SETTING_PLAN [8] = '{
    '{2'd1, 1'b0}, '{2'd0, 1'b1}, '{2'd2, 1'b1}, '{2'd3, 1'b0},
    '{2'd0, 1'b0}, '{2'd1, 1'b1}, '{2'd2, 1'b0}, '{2'd3, 1'b1}
  };

  // Keeps its own copy of the display state and the expected scan results.
  class display_model;
    logic [1:0]  digit_count;
    logic        active_high;
    logic [2:0]  phase;
    logic [7:0]  patterns [msd_pkg::DIGIT_COUNT_MAX];
    logic [10:0] expected_scans [$];   // common_levels, segment_levels
    int          mismatches;

    function new();
      digit_count = 2'd3;
      active_high = 1'b1;
      phase       = '0;
      foreach (patterns[i]) patterns[i] = '0;
      mismatches  = 0;
    endfunction

    function void write_config(logic index, logic [1:0] data);
      if (index == msd_pkg::CFG_DIGIT_COUNT) digit_count = data;
      else active_high = data[0];
    endfunction

    function int shown_digits();
      return (int'(digit_count) > msd_pkg::DIGIT_COUNT_MAX) ?
             msd_pkg::DIGIT_COUNT_MAX : int'(digit_count);
    endfunction

    function void store_value(longint unsigned v);
      for (int i = 0; i < shown_digits(); i++) begin
        patterns[i] = DIGIT_GLYPHS[v % 10];
        v = v / 10;
      end
    endfunction

    function void scan();
      logic [7:0] seg;
      logic [2:0] com;
      seg = 8'h00;
      if (int'(phase) < shown_digits()) seg = patterns[phase];
      if (!active_high) seg = ~seg;
      case (phase)
        3'd0:    com = 3'b110;
        3'd1:    com = 3'b101;
        3'd2:    com = 3'b011;
        default: com = 3'b111;
      endcase
      expected_scans.push_back({com, seg});
      phase = (int'(phase) == msd_pkg::SCAN_PHASES - 1) ? 3'd0 : phase + 3'd1;
    endfunction

    function void note_request(msd_pkg::func_e func, logic [19:0] value,
                               logic [1:0] point_pos);
      longint unsigned scaled;
      case (func)
        msd_pkg::FUNC_TICK:    scan();
        msd_pkg::FUNC_SET_INT: store_value(value);
        msd_pkg::FUNC_SET_FIXED: begin
          // Scale by the number of decimal places, then round half up.
          scaled = value;
          repeat (point_pos) scaled = scaled * 10;
          store_value((scaled + msd_pkg::ROUND_HALF) >> msd_pkg::FRAC_BITS);
          if (point_pos < msd_pkg::DIGIT_COUNT_MAX) patterns[point_pos] |= msd_pkg::POINT_BIT;
        end
        default: begin
          for (int i = 0; i < shown_digits(); i++) patterns[i] = '0;
          scan();
        end
      endcase
    endfunction

    function void report(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_scan(logic [15:0] data);
      logic [10:0] want;
      if (expected_scans.size() == 0) begin
        report("unexpected result", 0, data);
        return;
      end
      want = expected_scans.pop_front();
      if (data[7:0] !== want[7:0]) report("segment_levels", want[7:0], data[7:0]);
      if (data[10:8] !== want[10:8]) report("common_levels", want[10:8], data[10:8]);
    endfunction

    function int pending();
      return expected_scans.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // value [19:0], point_pos [21:20]
  logic [1:0]  s_axis_tuser  = '0;   // func [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // segment_levels [7:0], common_levels [10:8]
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = 1'b0;
  logic [1:0]  cfg_wdata_i   = '0;

  display_model board = new();
  bit           no_idle = 1'b0;
  int           cycles  = 0;

  multiplexed_seven_segment_driver_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int idle_draw();
    if (no_idle) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 15));
  endfunction

  task automatic send_request(request_t req);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.func;
    s_axis_tdata  <= {2'b00, req.point_pos, req.value};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(req.func, req.value, req.point_pos);
  endtask

  task automatic send_random();
    request_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      req.func = msd_pkg::FUNC_TICK;
    else if (pick < 65) req.func = msd_pkg::FUNC_SET_INT;
    else if (pick < 88) req.func = msd_pkg::FUNC_SET_FIXED;
    else                req.func = msd_pkg::FUNC_CLEAR;
    case ($urandom_range(0, 3))
      0:       req.value = 20'($urandom_range(0, 20'hFFFFF));
      1:       req.value = 20'($urandom_range(0, 999));
      // Fractions right at the rounding boundary.
      2:       req.value = {12'($urandom), ($urandom_range(0, 1) == 1) ? 8'h80 : 8'h7F};
      default: req.value = ($urandom_range(0, 1) == 1) ? VALUE_ALL_ONES : 20'd0;
    endcase
    req.point_pos = 2'($urandom_range(0, 3));
    send_request(req);
  endtask

  // Stops the sender until every result is back and the front stages are empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(setting_t s);
    logic [1:0] polarity_word;
    polarity_word = {1'($urandom), s.active_high};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= msd_pkg::CFG_DIGIT_COUNT;
    cfg_wdata_i <= s.digit_count;
    @(posedge clk_i);
    board.write_config(msd_pkg::CFG_DIGIT_COUNT, s.digit_count);
    cfg_index_i <= msd_pkg::CFG_ACTIVE_HIGH;
    cfg_wdata_i <= polarity_word;
    @(posedge clk_i);
    board.write_config(msd_pkg::CFG_ACTIVE_HIGH, polarity_word);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : result_side
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_scan(m_axis_tdata);
    end
  end

  initial begin : request_side
    request_t directed [25];
    directed = '{
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_SET_INT,   20'd123,        2'd0},
      '{msd_pkg::FUNC_TICK,      VALUE_ALL_ONES, 2'd3},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      // Scale by a thousand, no decimal point.
      '{msd_pkg::FUNC_SET_FIXED, VALUE_ALL_ONES, 2'd3},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_SET_FIXED, 20'h00180,      2'd1},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_SET_FIXED, 20'h00080,      2'd0},
      '{msd_pkg::FUNC_SET_FIXED, 20'h0007F,      2'd2},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_SET_INT,   VALUE_ALL_ONES, 2'd3},
      '{msd_pkg::FUNC_CLEAR,     VALUE_ALL_ONES, 2'd3},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_SET_FIXED, VALUE_ALL_ONES, 2'd2},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_TICK,      20'd0,          2'd0},
      '{msd_pkg::FUNC_CLEAR,     20'd0,          2'd0},
      '{msd_pkg::FUNC_SET_FIXED, 20'd0,          2'd0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i]);

    for (int phase_idx = 0; phase_idx <= $size(SETTING_PLAN); phase_idx++) begin
      if (phase_idx > 0) begin
        drain();
        apply_setting(SETTING_PLAN[phase_idx - 1]);
      end
      // Every third phase runs both sides without gaps.
      no_idle = (phase_idx % 3 == 2);
      repeat (RANDOM_PER_PHASE) send_random();
    end

    no_idle = 1'b0;
    drain();
    repeat (40) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
